// File: rtl/core/tpgf_pkg.sv
// Shared constants, register codes and tables for the tau-p ghost filter.
package tpgf_pkg;

    // Default spectrum sample width.
    localparam int SAMPLE_WIDTH_DEF = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH   = 2'd0,
        CFG_INV_VEL = 2'd1,
        CFG_STAB    = 2'd2
    } cfg_index_t;

    localparam logic [19:0] INV_VEL_RESET = 20'd715828;

    // Fixed-point constants of the datapath.
    localparam int          SQRT_STEPS   = 30;
    localparam int          CORDIC_STEPS = 24;
    localparam int          CORDIC_W     = 34;
    localparam int          DIV_STEPS    = 31;
    localparam int          DEN_FRAC     = 13;
    localparam logic [20:0] PHASE_RECIP  = 21'd1367131;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turns.
    localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

endpackage

// File: rtl/core/tau_p_ghost_filter.sv
// Tau-p receiver deghosting filter: kz, ghost phase, CORDIC and complex division pipeline.
// Throughput: one request per cycle unless the output stalls; the square root
// (30 stages), the CORDIC (24 stages) and the four dividers (31 stages each) are
// fully pipelined, one bit or step per stage.
// A result not taken stalls every stage together; nothing is lost or repeated.
// Reset clears all valid bits and loads the configuration registers with their reset values.
module tau_p_ghost_filter #(
    parameter int SAMPLE_WIDTH = tpgf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [tpgf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpgf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input request channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [23:0]                       s_omega,
    input  logic signed [20:0]                s_slowness,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_spec_re,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_spec_im,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_up_re,
    output logic signed [31:0]                m_up_im,
    output logic signed [31:0]                m_down_re,
    output logic signed [31:0]                m_down_im,
    output logic                              m_propagating,
    output logic                              m_clipped
);
    import tpgf_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int NW  = SW + 35;           // numerator width
    localparam int NNW = NW + DEN_FRAC;     // scaled numerator width
    localparam int HW  = NNW - DIV_STEPS;   // high part compared against the divisor

    // Stage positions along the pipeline.
    localparam int ST_A   = 2 + SQRT_STEPS;
    localparam int ST_X   = ST_A + 1;
    localparam int ST_T   = ST_X + 1;
    localparam int ST_CI  = ST_T + 1;
    localparam int ST_QS  = ST_CI + CORDIC_STEPS + 1;
    localparam int ST_DEN = ST_QS + 1;
    localparam int ST_PR1 = ST_DEN + 1;
    localparam int ST_DVI = ST_PR1 + 4;
    localparam int ST_OUT = ST_DVI + DIV_STEPS + 1;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic                 prop;
        logic [23:0]          omega;
        logic signed [SW-1:0] ure;
        logic signed [SW-1:0] uim;
    } carry_t;

    // Configuration registers.
    logic [15:0] depth_reg;
    logic [19:0] inv_vel_reg;
    logic [17:0] stab_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            inv_vel_reg <= INV_VEL_RESET;
            stab_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEPTH:   depth_reg   <= cfg_data[15:0];
                CFG_INV_VEL: inv_vel_reg <= cfg_data;
                CFG_STAB:    stab_reg    <= cfg_data[17:0];
                default:     ;
            endcase
        end
    end

    // Global advance: every stage moves unless the output holds an untaken result.
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en      = !vld_reg[NST-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // Side data that travels with each request.
    carry_t cry_reg [NST];

    // Stage 0: squares of the slownesses.
    logic [39:0] iv2_reg;
    logic [40:0] p2_reg;
    logic [20:0] pabs;

    assign pabs = s_slowness[20] ? (~s_slowness + 21'd1) : s_slowness;

    always_ff @(posedge aclk) begin
        if (en) begin
            iv2_reg    <= inv_vel_reg * inv_vel_reg;
            p2_reg     <= pabs * pabs;
            cry_reg[0] <= '{prop: 1'b0, omega: s_omega, ure: s_spec_re, uim: s_spec_im};
        end
    end

    // Stage 1: propagation test and square-root operand.
    logic [SQRT_STEPS+1:0] sq_rem_reg  [SQRT_STEPS+1];
    logic [SQRT_STEPS-1:0] sq_root_reg [SQRT_STEPS+1];
    logic [59:0]           sq_v_reg    [SQRT_STEPS+1];
    logic                  prop1;
    logic [40:0]           kz_diff;

    assign prop1   = (41'(iv2_reg) > p2_reg) && (cry_reg[0].omega != 24'd0);
    assign kz_diff = 41'(iv2_reg) - p2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_v_reg[0]    <= prop1 ? {kz_diff[39:0], 20'd0} : 60'd0;
            cry_reg[1]     <= '{prop: prop1, omega: cry_reg[0].omega,
                                ure: cry_reg[0].ure, uim: cry_reg[0].uim};
        end
    end

    // Carry pipeline.
    for (genvar i = 2; i < NST; i++) begin : g_cry
        always_ff @(posedge aclk) begin
            if (en) begin
                cry_reg[i] <= cry_reg[i-1];
            end
        end
    end

    // Digit-by-digit square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [SQRT_STEPS+3:0] rem_sh;
        logic [SQRT_STEPS+3:0] trial;
        logic                  take;

        assign rem_sh = {sq_rem_reg[k], sq_v_reg[k][59-2*k -: 2]};
        assign trial  = {2'b00, sq_root_reg[k], 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
                if (take) begin
                    sq_rem_reg[k+1]  <= (SQRT_STEPS+2)'(rem_sh - trial);
                    sq_root_reg[k+1] <= {sq_root_reg[k][SQRT_STEPS-2:0], 1'b1};
                end else begin
                    sq_rem_reg[k+1]  <= rem_sh[SQRT_STEPS+1:0];
                    sq_root_reg[k+1] <= {sq_root_reg[k][SQRT_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // Phase: kz scaled by depth, then turns.
    logic [53:0] a_reg;
    logic [49:0] x_reg;
    logic [31:0] t_reg;
    logic [70:0] ph_prod;

    assign ph_prod = x_reg * PHASE_RECIP;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= cry_reg[ST_A-1].omega * sq_root_reg[SQRT_STEPS];
            x_reg <= depth_reg * a_reg[53:20];
            t_reg <= ph_prod[63:32];
        end
    end

    // Quarter-turn folding and CORDIC start.
    logic signed [CORDIC_W-1:0] cd_x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cd_y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cd_z_reg [CORDIC_STEPS+1];
    logic [1:0]                 cd_q_reg [CORDIC_STEPS+1];
    logic [31:0]                t_rot;
    logic [31:0]                t_red;

    assign t_rot = t_reg + 32'h4000_0000;
    assign t_red = t_reg - {t_rot[31:30], 30'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_q_reg[0] <= t_rot[31:30];
            cd_z_reg[0] <= CORDIC_W'($signed(t_red));
            cd_x_reg[0] <= CORDIC_GAIN;
            cd_y_reg[0] <= '0;
        end
    end

    // CORDIC rotation, one micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                cd_q_reg[i+1] <= cd_q_reg[i];
                if (!cd_z_reg[i][CORDIC_W-1]) begin
                    cd_x_reg[i+1] <= cd_x_reg[i] - (cd_y_reg[i] >>> i);
                    cd_y_reg[i+1] <= cd_y_reg[i] + (cd_x_reg[i] >>> i);
                    cd_z_reg[i+1] <= cd_z_reg[i] - ATAN_TURNS[i];
                end else begin
                    cd_x_reg[i+1] <= cd_x_reg[i] + (cd_y_reg[i] >>> i);
                    cd_y_reg[i+1] <= cd_y_reg[i] - (cd_x_reg[i] >>> i);
                    cd_z_reg[i+1] <= cd_z_reg[i] + ATAN_TURNS[i];
                end
            end
        end
    end

    // Quadrant restore and reduction to Q13.
    logic signed [CORDIC_W-1:0] co;
    logic signed [CORDIC_W-1:0] si;
    logic signed [14:0]         c_reg;
    logic signed [14:0]         sn_reg;

    always_comb begin
        unique case (cd_q_reg[CORDIC_STEPS])
            2'd0: begin
                co = cd_x_reg[CORDIC_STEPS];
                si = cd_y_reg[CORDIC_STEPS];
            end
            2'd1: begin
                co = -cd_y_reg[CORDIC_STEPS];
                si = cd_x_reg[CORDIC_STEPS];
            end
            2'd2: begin
                co = -cd_x_reg[CORDIC_STEPS];
                si = -cd_y_reg[CORDIC_STEPS];
            end
            default: begin
                co = cd_y_reg[CORDIC_STEPS];
                si = -cd_x_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg  <= co[31:17];
            sn_reg <= si[31:17];
        end
    end

    // Denominator 1 - e + stabiliser.
    logic signed [17:0] dre_reg;
    logic signed [14:0] dim_reg;
    logic signed [14:0] c2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dre_reg <= 18'sd8192 - 18'(c_reg) + $signed({3'b000, stab_reg[17:3]});
            dim_reg <= sn_reg;
            c2_reg  <= c_reg;
        end
    end

    // Products of the spectrum with the denominator and ghost operator; |den|^2.
    logic signed [36:0]    mag_full;
    logic [32:0]           mag_reg;
    logic signed [SW+17:0] p_rd_reg;
    logic signed [SW+17:0] p_id_reg;
    logic signed [SW+14:0] p_im_reg;
    logic signed [SW+14:0] p_rm_reg;
    logic signed [SW+14:0] cu_reg;
    logic signed [SW+14:0] su_reg;
    logic signed [SW+14:0] cv_reg;
    logic signed [SW+14:0] sv_reg;
    logic signed [17:0]    dre2_reg;
    logic signed [14:0]    dim2_reg;

    assign mag_full = dre_reg * dre_reg + dim_reg * dim_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_full[32:0];
            p_rd_reg <= cry_reg[ST_PR1-1].ure * dre_reg;
            p_id_reg <= cry_reg[ST_PR1-1].uim * dre_reg;
            p_im_reg <= cry_reg[ST_PR1-1].uim * dim_reg;
            p_rm_reg <= cry_reg[ST_PR1-1].ure * dim_reg;
            cu_reg   <= cry_reg[ST_PR1-1].ure * c2_reg;
            su_reg   <= cry_reg[ST_PR1-1].uim * dim_reg;
            cv_reg   <= cry_reg[ST_PR1-1].uim * c2_reg;
            sv_reg   <= cry_reg[ST_PR1-1].ure * dim_reg;
            dre2_reg <= dre_reg;
            dim2_reg <= dim_reg;
        end
    end

    // Upgoing numerators and the ghost-weighted spectrum W.
    logic signed [NW-1:0]  nup_reg [2];
    logic signed [SW+15:0] wre_reg;
    logic signed [SW+15:0] wim_reg;
    logic [32:0]           mag2_reg;
    logic signed [17:0]    dre3_reg;
    logic signed [14:0]    dim3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nup_reg[0] <= p_rd_reg + p_im_reg;
            nup_reg[1] <= p_id_reg - p_rm_reg;
            wre_reg    <= -cu_reg - su_reg;
            wim_reg    <= -cv_reg + sv_reg;
            mag2_reg   <= mag_reg;
            dre3_reg   <= dre2_reg;
            dim3_reg   <= dim2_reg;
        end
    end

    // Products of W with the conjugate denominator.
    logic signed [SW+33:0] m_rd_reg;
    logic signed [SW+33:0] m_id_reg;
    logic signed [SW+33:0] m_im_reg;
    logic signed [SW+33:0] m_rm_reg;
    logic signed [NW-1:0]  nup2_reg [2];
    logic [32:0]           mag3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_rd_reg    <= wre_reg * dre3_reg;
            m_im_reg    <= wim_reg * dim3_reg;
            m_id_reg    <= wim_reg * dre3_reg;
            m_rm_reg    <= wre_reg * dim3_reg;
            nup2_reg[0] <= nup_reg[0];
            nup2_reg[1] <= nup_reg[1];
            mag3_reg    <= mag2_reg;
        end
    end

    // All four numerators side by side.
    logic signed [NW-1:0] num_reg [4];
    logic [32:0]          mag4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= nup2_reg[0];
            num_reg[1] <= nup2_reg[1];
            num_reg[2] <= m_rd_reg + m_im_reg;
            num_reg[3] <= m_id_reg - m_rm_reg;
            mag4_reg   <= mag3_reg;
        end
    end

    // Divider state per lane; index 0 is the set-up stage.
    logic [32:0]          dv_mag_reg [DIV_STEPS+1];
    logic [32:0]          dv_rem_reg [4][DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_q_reg   [4][DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_low_reg [4][DIV_STEPS+1];
    logic                 dv_neg_reg [4][DIV_STEPS+1];
    logic                 dv_sat_reg [4][DIV_STEPS+1];
    logic                 dv_top_reg [4][DIV_STEPS+1];
    logic                 dv_zero_reg[4][DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_mag_reg[0] <= mag4_reg;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dmag
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_mag_reg[j+1] <= dv_mag_reg[j];
            end
        end
    end

    logic signed [31:0] res [4];
    logic               lane_sat [4];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        localparam int SH = (l < 2) ? DEN_FRAC : 0;

        logic           neg;
        logic [NW-1:0]  nabs;
        logic [NNW-1:0] nsc;
        logic [HW-1:0]  nhi;
        logic [HW-1:0]  mag_ext;
        logic [HW:0]    mag_x2;
        logic           top;
        logic           clip;
        logic [31:0]    qfull;
        logic [31:0]    qmag;
        logic [31:0]    lim;

        // Magnitude and scaling. The quotient reaches 2^32 when the high part is
        // at least twice the divisor; otherwise its top bit is settled here and
        // the remaining 31 bits come from the stages below.
        assign neg     = num_reg[l][NW-1];
        assign nabs    = neg ? (~num_reg[l] + NW'(1)) : num_reg[l];
        assign nsc     = NNW'(nabs) << SH;
        assign nhi     = nsc[NNW-1:DIV_STEPS];
        assign mag_ext = HW'(mag4_reg);
        assign mag_x2  = {mag_ext, 1'b0};
        assign top     = nhi >= mag_ext;

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_neg_reg[l][0]  <= neg;
                dv_zero_reg[l][0] <= (nabs == '0);
                dv_sat_reg[l][0]  <= ({1'b0, nhi} >= mag_x2);
                dv_top_reg[l][0]  <= top;
                dv_rem_reg[l][0]  <= top ? 33'(nhi - mag_ext) : 33'(nhi);
                dv_low_reg[l][0]  <= nsc[DIV_STEPS-1:0];
                dv_q_reg[l][0]    <= '0;
            end
        end

        // Restoring division, one quotient bit per stage.
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
            logic [33:0] rem_sh;
            logic        take;

            assign rem_sh = {dv_rem_reg[l][j], dv_low_reg[l][j][DIV_STEPS-1-j]};
            assign take   = rem_sh >= {1'b0, dv_mag_reg[j]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_neg_reg[l][j+1]  <= dv_neg_reg[l][j];
                    dv_zero_reg[l][j+1] <= dv_zero_reg[l][j];
                    dv_sat_reg[l][j+1]  <= dv_sat_reg[l][j];
                    dv_top_reg[l][j+1]  <= dv_top_reg[l][j];
                    dv_low_reg[l][j+1]  <= dv_low_reg[l][j];
                    dv_q_reg[l][j+1]    <= {dv_q_reg[l][j][DIV_STEPS-2:0], take};
                    if (take) begin
                        dv_rem_reg[l][j+1] <= 33'(rem_sh - {1'b0, dv_mag_reg[j]});
                    end else begin
                        dv_rem_reg[l][j+1] <= rem_sh[32:0];
                    end
                end
            end
        end

        // Saturation and sign of the finished quotient. A negative result of
        // exactly -2^31 is representable and does not count as clipped.
        assign qfull = {dv_top_reg[l][DIV_STEPS], dv_q_reg[l][DIV_STEPS]};
        assign clip  = dv_sat_reg[l][DIV_STEPS] ||
                       (dv_top_reg[l][DIV_STEPS] &&
                        (!dv_neg_reg[l][DIV_STEPS] || (dv_q_reg[l][DIV_STEPS] != '0)));
        assign lim   = dv_neg_reg[l][DIV_STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        assign qmag  = dv_zero_reg[l][DIV_STEPS] ? 32'd0 :
                       clip                      ? lim :
                       qfull;
        assign res[l]      = dv_neg_reg[l][DIV_STEPS] ? $signed(32'd0 - qmag)
                                                      : $signed(qmag);
        assign lane_sat[l] = clip && !dv_zero_reg[l][DIV_STEPS];
    end

    // Output register; evanescent requests give zeros.
    logic prop_out;

    assign prop_out = cry_reg[ST_OUT-1].prop;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_propagating <= prop_out;
            m_up_re       <= prop_out ? res[0] : 32'sd0;
            m_up_im       <= prop_out ? res[1] : 32'sd0;
            m_down_re     <= prop_out ? res[2] : 32'sd0;
            m_down_im     <= prop_out ? res[3] : 32'sd0;
            m_clipped     <= prop_out &&
                             (lane_sat[0] || lane_sat[1] || lane_sat[2] || lane_sat[3]);
        end
    end

endmodule

// File: verif/tb.sv
// Self-checking testbench for the tau-p receiver deghosting filter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpgf_pkg::*;

    localparam int          SW          = SAMPLE_WIDTH_DEF;
    localparam int          STALL_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 120;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;

    typedef struct {
        logic [31:0] up_re;
        logic [31:0] up_im;
        logic [31:0] down_re;
        logic [31:0] down_im;
        logic        propagating;
        logic        clipped;
    } deghost_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [23:0]           s_omega = '0;
    logic signed [20:0]    s_slowness = '0;
    logic signed [SW-1:0]  s_spec_re = '0;
    logic signed [SW-1:0]  s_spec_im = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_up_re, m_up_im, m_down_re, m_down_im;
    logic                  m_propagating, m_clipped;

    // Shadow copy of the configuration registers.
    logic [15:0] depth_q = 16'd0;
    logic [19:0] inv_vel_q = INV_VEL_RESET;
    logic [17:0] stab_q = 18'd0;

    deghost_t    wavefields_due[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    int          ready_hold = 0;

    tau_p_ghost_filter #(.SAMPLE_WIDTH(SW)) i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Rotation by the ghost phase after folding into the principal quarter turn.
    task automatic ghost_rotate(input logic [31:0] turns, output longint co, output longint si);
        logic [31:0] shifted, ru;
        logic [1:0]  quad;
        longint      x, y, z, nx;
        shifted = turns + 32'h4000_0000;
        quad = shifted[31:30];
        ru = turns - {quad, 30'd0};
        z = longint'($signed(ru));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TURNS[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        case (quad)
            2'd0: begin co = x; si = y; end
            2'd1: begin co = -y; si = x; end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
    endtask

    // Truncating division with saturation to 32 bits.
    function automatic logic [31:0] sat_quotient(input longint num, input int sh,
                                                 input longint unsigned mag, inout bit clip);
        bit              neg;
        longint unsigned n, lim, q, q1, r;
        neg = num < 0;
        n = neg ? longint'(-(num + 1)) + 64'd1 : num;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (n == 0) return 32'd0;
        if (mag == 0) begin
            clip = 1'b1;
            q = lim;
        end else begin
            q1 = n / mag;
            r = n % mag;
            if (q1 >= 64'h8000_0000) begin
                q = lim;
                clip = 1'b1;
            end else begin
                q = (q1 << sh) + ((r << sh) / mag);
                if (q > lim) begin
                    q = lim;
                    clip = 1'b1;
                end
            end
        end
        return neg ? 32'(64'd0 - q) : q[31:0];
    endfunction

    task automatic predict_wavefields(input logic [23:0] omega, input logic signed [20:0] p,
                                      input logic signed [SW-1:0] ure_in,
                                      input logic signed [SW-1:0] uim_in,
                                      output deghost_t res);
        longint unsigned iv, iv2, pa, p2, s, a, x, prod, mag;
        longint          ure, uim, c30, s30, c, sn, dre, dim, wre, wim;
        bit              clip;
        res = '{default: '0};
        clip = 1'b0;
        iv = inv_vel_q;
        iv2 = iv * iv;
        pa = (p < 0) ? longint'(-longint'(p)) : longint'(p);
        p2 = pa * pa;
        if (iv2 <= p2 || omega == 0) return;
        ure = ure_in;
        uim = uim_in;
        s = int_sqrt((iv2 - p2) << 20);
        a = longint'(omega) * s;
        x = longint'(depth_q) * (a >> 20);
        prod = x * 64'd1367131;
        ghost_rotate(prod[63:32], c30, s30);
        c = c30 >>> (30 - DEN_FRAC);
        sn = s30 >>> (30 - DEN_FRAC);
        dre = (longint'(1) << DEN_FRAC) - c + longint'(stab_q >> 3);
        dim = sn;
        mag = dre * dre + dim * dim;
        wre = -c * ure - sn * uim;
        wim = -c * uim + sn * ure;
        res.up_re = sat_quotient(ure * dre + uim * dim, DEN_FRAC, mag, clip);
        res.up_im = sat_quotient(uim * dre - ure * dim, DEN_FRAC, mag, clip);
        res.down_re = sat_quotient(wre * dre + wim * dim, 0, mag, clip);
        res.down_im = sat_quotient(wim * dre - wre * dim, 0, mag, clip);
        res.propagating = 1'b1;
        res.clipped = clip;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Send one request and record its expected wavefields once it is taken.
    task automatic send_bin(input logic [23:0] omega, input logic signed [20:0] p,
                            input logic signed [SW-1:0] ure, input logic signed [SW-1:0] uim);
        deghost_t res;
        int       gap;
        s_valid <= 1'b1;
        s_omega <= omega;
        s_slowness <= p;
        s_spec_re <= ure;
        s_spec_im <= uim;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_wavefields(omega, p, ure, uim, res);
        wavefields_due.push_back(res);
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (wavefields_due.size() != 0) @(posedge aclk);
    endtask

    // Writes all three registers plus one to an unused index, only while idle.
    task automatic set_config(input logic [15:0] depth, input logic [19:0] iv,
                              input logic [17:0] stab);
        s_valid <= 1'b0;
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEPTH;
        cfg_data <= 20'(depth);
        @(posedge aclk);
        cfg_index <= CFG_INV_VEL;
        cfg_data <= iv;
        @(posedge aclk);
        cfg_index <= CFG_STAB;
        cfg_data <= 20'(stab);
        @(posedge aclk);
        cfg_index <= CFG_UNUSED;
        cfg_data <= 20'($urandom());
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        depth_q = depth;
        inv_vel_q = iv;
        stab_q = stab;
    endtask

    // Slowness mostly inside the propagating cone, sometimes on or outside it.
    function automatic logic signed [20:0] pick_slowness();
        int                 r;
        int                 lim;
        logic signed [20:0] v;
        r = $urandom_range(0, 99);
        lim = int'(inv_vel_q);
        if (r < 80 && lim > 0) begin
            v = 21'($urandom_range(0, lim - 1));
            return $urandom_range(0, 1) ? v : -v;
        end
        if (r < 88) return ($urandom_range(0, 1) ? 21'(lim) : -21'(lim));
        return 21'($urandom());
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(SW-1){1'b0}}};
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return SW'($urandom_range(0, 255)) - SW'(128);
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] pick_omega();
        case ($urandom_range(0, 19))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom_range(1, 4096));
            default: return 24'($urandom());
        endcase
    endfunction

    // Field extremes, evanescent bins and the zero-denominator case at depth zero.
    task automatic test_extremes();
        logic signed [SW-1:0] smax, smin;
        smax = {1'b0, {(SW-1){1'b1}}};
        smin = {1'b1, {(SW-1){1'b0}}};
        send_bin(24'd4096, 21'sd0, 24'sd1000, -24'sd1000);
        send_bin(24'd4096, 21'sd0, 24'sd0, 24'sd0);
        send_bin(24'd0, 21'sd0, smax, smax);
        send_bin(24'hFF_FFFF, 21'sd0, smin, smax);
        send_bin(24'hFF_FFFF, -21'sd1048576, smax, smin);
        send_bin(24'd100, 21'sd715828, 24'sd5, 24'sd5);
        send_bin(24'd100, -21'sd715827, 24'sd5, 24'sd5);
        set_config(16'd1500, 20'd715828, 18'd0);
        send_bin(24'd4096, 21'sd0, smax, smax);
        send_bin(24'hFF_FFFF, 21'sd1048575, smin, smin);
        send_bin(24'd123456, 21'sd300000, 24'sd77777, -24'sd12345);
        send_bin(24'hFF_FFFF, -21'sd1, smin, 24'sd0);
        set_config(16'hFFFF, 20'hF_FFFF, 18'h3_FFFF);
        send_bin(24'hFF_FFFF, 21'sd1048575, smax, smin);
        send_bin(24'd1, -21'sd1048576, smin, smax);
        send_bin(24'h80_0000, 21'sd0, smax, 24'sd1);
        set_config(16'd0, 20'd0, 18'd0);
        send_bin(24'd4096, 21'sd0, smax, smax);
        send_bin(24'hFF_FFFF, -21'sd1048576, smin, smin);
    endtask

    // Random bins over a range of register settings, with idle stretches and a full drain.
    task automatic test_random_bins();
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_config(16'd10000, 20'd715828, 18'd1000);
                1: set_config(16'hFFFF, 20'hF_FFFF, 18'd0);
                2: set_config(16'd1, 20'd1, 18'h3_FFFF);
                default: set_config(16'($urandom()), 20'($urandom()), 18'($urandom()));
            endcase
            no_idle = (phase == 3);
            for (int k = 0; k < 250; k++) begin
                send_bin(pick_omega(), pick_slowness(), pick_sample(), pick_sample());
                if (k == 125 && phase == 4) begin
                    s_valid <= 1'b0;
                    drain();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side stalls at random.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            ready_hold <= gap_len();
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        deghost_t want;
        if (aresetn && m_valid && m_ready) begin
            if (wavefields_due.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = wavefields_due.pop_front();
                if (m_up_re !== want.up_re)
                    report_mismatch("up_re", m_up_re, $signed(want.up_re));
                if (m_up_im !== want.up_im)
                    report_mismatch("up_im", m_up_im, $signed(want.up_im));
                if (m_down_re !== want.down_re)
                    report_mismatch("down_re", m_down_re, $signed(want.down_re));
                if (m_down_im !== want.down_im)
                    report_mismatch("down_im", m_down_im, $signed(want.down_im));
                if (m_propagating !== want.propagating)
                    report_mismatch("propagating", m_propagating, want.propagating);
                if (m_clipped !== want.clipped)
                    report_mismatch("clipped", m_clipped, want.clipped);
            end
        end
    end

    // Watchdog on cycles with no request moving on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_random_bins();
        s_valid <= 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (wavefields_due.size() != 0)
            report_mismatch("results missing", 0, wavefields_due.size());
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/tpgf_pkg.sv
rtl/core/tau_p_ghost_filter.sv
verif/tb.sv
